[rtl/opd_pkg.sv]
// ----------------------------------------------------------------------------
// opd_pkg
// Shared types and constants of the oscillation period detector: payload
// structs, differentiator taps and the column-sum helper of the serial
// differentiator.
// ----------------------------------------------------------------------------
package opd_pkg;

	// Field widths fixed by the interface.
	localparam int SAMPLE_W = 32;
	localparam int STAMP_W  = 32;
	localparam int DERIV_W  = 43;
	localparam int RATIO_W  = 32;

	// Window and stamp history depths.
	localparam int WIN_LEN   = 11;
	localparam int STAMP_LEN = 3;
	localparam int FILL_W    = 4;
	localparam int CNT_W     = 2;

	// Reset value of the ratio register, 1.0 in Q16.16.
	localparam logic [RATIO_W-1:0] RATIO_RESET = 32'h0001_0000;

	// The quotient is one bit per cycle over the ratio width.
	localparam int DIV_CNT_W = $clog2(RATIO_W);

	// Column sums lie within +/-660, the running carry within the same bound.
	localparam int COL_W   = 12;
	localparam int NUM_TAP = 5;

	// Tap pairs: coefficient k weighs (w[6+k] - w[4-k]).
	localparam logic signed [COL_W-1:0] TAP_COEF [NUM_TAP] = '{
		12'sd322, 12'sd256, 12'sd39, -12'sd32, -12'sd11
	};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic        [STAMP_W-1:0]  time_step;
	} in_t;

	typedef struct packed {
		logic signed [DERIV_W-1:0] derivative;
		logic                      derivative_valid;
		logic                      rising;
		logic                      period_valid;
		logic [STAMP_W-1:0]        period;
		logic [RATIO_W-1:0]        strouhal;
	} out_t;

	// Weighted sum of one bit column of the window.
	function automatic logic signed [COL_W-1:0] col_sum(input logic [WIN_LEN-1:0] b);
		logic signed [COL_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < NUM_TAP; k++) begin
			if (b[6+k] && !b[4-k]) begin
				acc = acc + TAP_COEF[k];
			end else if (!b[6+k] && b[4-k]) begin
				acc = acc - TAP_COEF[k];
			end
		end
		return acc;
	endfunction

endpackage

[rtl/oscillation_period_detector_unit.sv]
// ----------------------------------------------------------------------------
// oscillation_period_detector_unit
// Smooth 11-tap differentiator over a sample window, sign-change stamping
// and a serial divider for the Strouhal figure.
//
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_ready    in_data  (sample, time_step)
// out      out  out_valid / out_ready  out_data (derivative ... strouhal)
// cfg      in   cfg_we                 cfg_data (diameter_over_velocity)
//
// A filling sample goes from idle straight to the hand-off state. With a full
// window the derivative is formed one bit per cycle over SAMPLE_BITS+11
// columns, and the input side stays closed until the item is handed off.
// The Strouhal quotient is formed one bit per cycle in the divider stage
// and runs while the next sample is differentiated.
// A result waits in the output register under a stall; the front stage keeps
// working and parks its item until the output stage is free.
// Reset is asynchronous; control state clears and ratio_q resets to 1.0 at once.
// ----------------------------------------------------------------------------
module oscillation_period_detector_unit
	import opd_pkg::*;
#(
	parameter int SAMPLE_BITS = 32,
	parameter int STAMP_BITS  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_t                in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_t               out_data,
	input  logic               cfg_we,
	input  logic [RATIO_W-1:0] cfg_data
);

	// Width of the exact derivative and of its column counter.
	localparam int DW    = SAMPLE_BITS + 11;
	localparam int BIT_W = $clog2(DW);

	typedef enum logic [2:0] {
		A_IDLE = 3'b001,
		A_RUN  = 3'b010,
		A_HAND = 3'b100
	} a_state_t;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_OUT  = 3'b100
	} b_state_t;

	a_state_t a_state_q;
	b_state_t b_state_q;

	logic [RATIO_W-1:0]     ratio_q;
	logic [SAMPLE_BITS-1:0] win_q [WIN_LEN];
	logic [FILL_W-1:0]      fill_q;
	logic [BIT_W-1:0]       bit_q;
	logic signed [COL_W-1:0] carry_q;
	logic [DW-1:0]          dacc_q;
	logic                   nz_q;
	logic                   dvalid_q;
	logic                   rising_q;
	logic [STAMP_BITS-1:0]  ts_q;
	logic [STAMP_BITS-1:0]  stamp_q [STAMP_LEN];
	logic [CNT_W-1:0]       cnt_q;

	logic [STAMP_BITS-1:0]  period_q;
	logic [STAMP_BITS-1:0]  rem_q;
	logic [RATIO_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	out_t                   out_q;

	// Transfers and stage events.
	logic in_xfer, out_xfer, hand, run_last;
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign hand     = (a_state_q == A_HAND) && (b_state_q == B_IDLE);
	assign run_last = (a_state_q == A_RUN) && (bit_q == BIT_W'(DW - 1));

	assign in_ready  = (a_state_q == A_IDLE);
	assign out_valid = (b_state_q == B_OUT);
	assign out_data  = out_q;

	// Field fitting to the parameter widths.
	logic [SAMPLE_BITS+SAMPLE_W-1:0] sample_ext;
	logic [STAMP_BITS+STAMP_W-1:0]   ts_ext;
	logic [DERIV_W+DW-1:0]           deriv_ext;
	logic [STAMP_BITS+STAMP_W-1:0]   period_ext;
	logic [STAMP_BITS-1:0]           period_new;
	assign sample_ext = {{SAMPLE_BITS{1'b0}}, in_data.sample};
	assign ts_ext     = {{STAMP_BITS{1'b0}}, in_data.time_step};
	assign deriv_ext  = {{DERIV_W{dacc_q[DW-1]}}, dacc_q};
	assign period_new = stamp_q[STAMP_LEN-1] - stamp_q[0];
	assign period_ext = {{STAMP_W{1'b0}}, period_new};

	// One bit column of the window, sign bits repeated above the sample width.
	logic [WIN_LEN-1:0]      col_bits;
	logic signed [COL_W-1:0] col_t;
	logic                    dbit;
	logic                    sign_ext_phase;
	logic                    pos;
	assign sign_ext_phase = (bit_q >= BIT_W'(SAMPLE_BITS));
	always_comb begin
		for (int k = 0; k < WIN_LEN; k++) begin
			col_bits[k] = sign_ext_phase ? win_q[k][SAMPLE_BITS-1] : win_q[k][0];
		end
		col_t = carry_q + col_sum(col_bits);
	end
	assign dbit = col_t[0];
	// The last column carries the sign; a zero derivative counts as not rising.
	assign pos  = (nz_q || dbit) && !dbit;

	// Divider step: shifted remainder against the period.
	logic [STAMP_BITS:0] div_sh, div_diff;
	logic                div_ge;
	assign div_sh   = {rem_q, quo_q[RATIO_W-1]};
	assign div_diff = div_sh - {1'b0, period_q};
	assign div_ge   = !div_diff[STAMP_BITS];

	// Front stage control, ratio register, sign state and stamp count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_state_q <= A_IDLE;
			ratio_q   <= RATIO_RESET;
			fill_q    <= '0;
			bit_q     <= '0;
			rising_q  <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				ratio_q <= cfg_data;
			end
			case (a_state_q)
				A_IDLE: begin
					if (in_xfer) begin
						bit_q <= '0;
						if (fill_q == FILL_W'(WIN_LEN)) begin
							a_state_q <= A_RUN;
						end else begin
							fill_q    <= fill_q + 1'b1;
							a_state_q <= A_HAND;
						end
					end
				end
				A_RUN: begin
					bit_q <= bit_q + 1'b1;
					if (run_last) begin
						a_state_q <= A_HAND;
						if (pos != rising_q) begin
							rising_q <= pos;
							if (cnt_q != CNT_W'(STAMP_LEN)) begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
					end
				end
				A_HAND: begin
					if (hand) begin
						a_state_q <= A_IDLE;
					end
				end
				default: a_state_q <= A_IDLE;
			endcase
		end
	end

	// Front stage datapath: window, serial derivative and stamp history.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			for (int k = 0; k < WIN_LEN - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[WIN_LEN-1] <= sample_ext[SAMPLE_BITS-1:0];
			ts_q     <= ts_ext[STAMP_BITS-1:0];
			dvalid_q <= (fill_q == FILL_W'(WIN_LEN));
			carry_q  <= '0;
			nz_q     <= 1'b0;
		end
		if (a_state_q == A_RUN) begin
			// Rotate the samples until every bit has passed the low end.
			if (!sign_ext_phase) begin
				for (int k = 0; k < WIN_LEN; k++) begin
					win_q[k] <= {win_q[k][0], win_q[k][SAMPLE_BITS-1:1]};
				end
			end
			carry_q <= col_t >>> 1;
			dacc_q  <= {dbit, dacc_q[DW-1:1]};
			nz_q    <= nz_q || dbit;
			if (run_last && (pos != rising_q)) begin
				if (cnt_q != CNT_W'(STAMP_LEN)) begin
					stamp_q[cnt_q] <= ts_q;
				end else begin
					for (int k = 0; k < STAMP_LEN - 1; k++) begin
						stamp_q[k] <= stamp_q[k+1];
					end
					stamp_q[STAMP_LEN-1] <= ts_q;
				end
			end
		end
	end

	// Output stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_state_q <= B_IDLE;
			div_cnt_q <= '0;
		end else begin
			case (b_state_q)
				B_IDLE: begin
					if (hand) begin
						div_cnt_q <= '0;
						if ((cnt_q == CNT_W'(STAMP_LEN)) && (period_new != '0)) begin
							b_state_q <= B_DIV;
						end else begin
							b_state_q <= B_OUT;
						end
					end
				end
				B_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(RATIO_W - 1)) begin
						b_state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_xfer) begin
						b_state_q <= B_IDLE;
					end
				end
				default: b_state_q <= B_IDLE;
			endcase
		end
	end

	// Output stage datapath: result capture and restoring division.
	always_ff @(posedge clk) begin
		if (hand) begin
			out_q.derivative       <= dvalid_q ? deriv_ext[DERIV_W-1:0] : '0;
			out_q.derivative_valid <= dvalid_q;
			out_q.rising           <= rising_q;
			if (cnt_q == CNT_W'(STAMP_LEN)) begin
				out_q.period_valid <= 1'b1;
				out_q.period       <= period_ext[STAMP_W-1:0];
				out_q.strouhal     <= '1;
			end else begin
				out_q.period_valid <= 1'b0;
				out_q.period       <= '0;
				out_q.strouhal     <= '0;
			end
			period_q <= period_new;
			rem_q    <= '0;
			quo_q    <= ratio_q;
		end
		if (b_state_q == B_DIV) begin
			rem_q <= div_ge ? div_diff[STAMP_BITS-1:0] : div_sh[STAMP_BITS-1:0];
			quo_q <= {quo_q[RATIO_W-2:0], div_ge};
			if (div_cnt_q == DIV_CNT_W'(RATIO_W - 1)) begin
				out_q.strouhal <= {quo_q[RATIO_W-2:0], div_ge};
			end
		end
	end

endmodule

[rtl/opd_checker.sv]
// ----------------------------------------------------------------------------
// opd_checker
// Port-level checks of the oscillation period detector, bound to the top.
// ----------------------------------------------------------------------------
module opd_checker
	import opd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// A stalled result holds its value until the transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// One item at a time: the input side closes right after a transfer.
	a_in_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input reopened right after a transfer");

	// While the window fills there is no derivative value.
	a_deriv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.derivative_valid |-> out_data.derivative == '0)
		else $error("derivative set without a full window");

	// Without three stamps both period and Strouhal read zero.
	a_no_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.period_valid |->
			out_data.period == '0 && out_data.strouhal == '0)
		else $error("period fields set before three stamps");

	// A zero period saturates the Strouhal figure.
	a_zero_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.period_valid && out_data.period == '0 |->
			out_data.strouhal == '1)
		else $error("zero period without saturation");

endmodule

bind oscillation_period_detector_unit opd_checker u_opd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
